/* sv/fbsa_pkg.sv */
package fbsa_pkg;

  localparam int WORD_W              = 32;
  localparam int MODE_W              = 2;
  localparam int KIND_W              = 3;
  localparam int INDEX_W             = 6;
  localparam int DEFAULT_STACK_DEPTH = 32;

  localparam logic [MODE_W-1:0] MODE_ALLOC   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_RECLAIM = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FILL    = 2'd2;

  localparam logic [KIND_W-1:0] KIND_GRANTED  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_REFUSED  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 3'd2;
  localparam logic [KIND_W-1:0] KIND_SPILL    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FILL_REQ = 3'd4;

endpackage

/* sv/fbsa_stack_mem.sv */
module fbsa_stack_mem #(
  parameter int DEPTH  = fbsa_pkg::DEFAULT_STACK_DEPTH,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [ADDR_W-1:0]           waddr,
  input  logic [fbsa_pkg::WORD_W-1:0] wdata,
  input  logic [ADDR_W-1:0]           raddr,
  output logic [fbsa_pkg::WORD_W-1:0] rdata
);
  import fbsa_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* sv/fbsa_ctrl.sv */
module fbsa_ctrl #(
  parameter int STACK_DEPTH = fbsa_pkg::DEFAULT_STACK_DEPTH,
  parameter int ADDR_W      = $clog2(STACK_DEPTH),
  parameter int COUNT_W     = $clog2(STACK_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [fbsa_pkg::MODE_W-1:0]  mode,
  input  logic [fbsa_pkg::WORD_W-1:0]  block_id,
  input  logic [fbsa_pkg::WORD_W-1:0]  fill_word,
  input  logic [fbsa_pkg::WORD_W-1:0]  max_blocks,
  output logic                         mem_we,
  output logic [ADDR_W-1:0]            mem_waddr,
  output logic [fbsa_pkg::WORD_W-1:0]  mem_wdata,
  output logic [ADDR_W-1:0]            mem_raddr,
  input  logic [fbsa_pkg::WORD_W-1:0]  mem_rdata,
  output logic                         strobe,
  output logic [fbsa_pkg::KIND_W-1:0]  kind,
  output logic [fbsa_pkg::WORD_W-1:0]  result_block,
  output logic [fbsa_pkg::INDEX_W-1:0] word_index,
  output logic [fbsa_pkg::WORD_W-1:0]  word_value,
  output logic                         last
);
  import fbsa_pkg::*;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_ALLOC   = 3'd1;
  localparam logic [2:0] ST_FILLREQ = 3'd2;
  localparam logic [2:0] ST_SPILL   = 3'd3;
  localparam logic [2:0] ST_DONE    = 3'd4;

  localparam logic [COUNT_W-1:0] COUNT_FULL = COUNT_W'(STACK_DEPTH);
  localparam logic [COUNT_W-1:0] COUNT_ONE  = COUNT_W'(1);
  localparam logic [ADDR_W-1:0]  ADDR_LAST  = ADDR_W'(STACK_DEPTH - 1);
  localparam logic [ADDR_W-1:0]  ADDR_ONE   = ADDR_W'(1);

  logic [2:0]         state, state_next;
  logic [COUNT_W-1:0] entry_count, entry_count_next;
  logic [WORD_W-1:0]  chain_first, chain_first_next;
  logic               refilling, refilling_next;
  logic [ADDR_W-1:0]  fill_position, fill_position_next;
  logic [ADDR_W-1:0]  spill_idx, spill_idx_next;
  logic [WORD_W-1:0]  held_id, held_id_next;

  logic               strobe_next;
  logic [KIND_W-1:0]  kind_next;
  logic [WORD_W-1:0]  result_block_next;
  logic [INDEX_W-1:0] word_index_next;
  logic [WORD_W-1:0]  word_value_next;
  logic               last_next;

  logic               accept;
  logic [COUNT_W-1:0] count_m1;

  assign busy     = (state != ST_IDLE);
  assign accept   = start && !busy;
  assign count_m1 = entry_count - COUNT_ONE;

  always_comb begin
    state_next         = state;
    entry_count_next   = entry_count;
    chain_first_next   = chain_first;
    refilling_next     = refilling;
    fill_position_next = fill_position;
    spill_idx_next     = spill_idx;
    held_id_next       = held_id;

    strobe_next        = 1'b0;
    kind_next          = KIND_REFUSED;
    result_block_next  = '0;
    word_index_next    = '0;
    word_value_next    = '0;
    last_next          = 1'b0;

    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = block_id;
    mem_raddr = count_m1[ADDR_W-1:0];

    case (state)
      ST_IDLE: begin
        if (accept) begin
          held_id_next = block_id;
          case (mode)
            MODE_FILL: begin
              if (refilling) begin
                mem_we    = 1'b1;
                mem_waddr = fill_position;
                mem_wdata = fill_word;
                if (fill_position == ADDR_LAST) begin
                  entry_count_next   = COUNT_FULL;
                  refilling_next     = 1'b0;
                  fill_position_next = '0;
                end else begin
                  fill_position_next = fill_position + ADDR_ONE;
                end
              end
            end
            MODE_ALLOC: begin
              if (refilling || entry_count == '0) begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
              end else begin
                state_next = ST_ALLOC;
              end
            end
            MODE_RECLAIM: begin
              if (refilling || block_id >= max_blocks) begin
                strobe_next = 1'b1;
                last_next   = 1'b1;
              end else begin
                if (entry_count == '0) begin
                  chain_first_next = block_id;
                end
                if (entry_count == COUNT_FULL) begin
                  mem_raddr      = '0;
                  spill_idx_next = '0;
                  state_next     = ST_SPILL;
                end else begin
                  mem_we            = 1'b1;
                  mem_waddr         = entry_count[ADDR_W-1:0];
                  entry_count_next  = entry_count + COUNT_ONE;
                  strobe_next       = 1'b1;
                  kind_next         = KIND_ACCEPTED;
                  result_block_next = block_id;
                  last_next         = 1'b1;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_ALLOC: begin
        strobe_next       = 1'b1;
        kind_next         = KIND_GRANTED;
        result_block_next = mem_rdata;
        if (entry_count == COUNT_ONE && mem_rdata != chain_first) begin
          entry_count_next   = '0;
          refilling_next     = 1'b1;
          fill_position_next = '0;
          held_id_next       = mem_rdata;
          state_next         = ST_FILLREQ;
        end else begin
          entry_count_next = count_m1;
          last_next        = 1'b1;
          state_next       = ST_IDLE;
        end
      end
      ST_FILLREQ: begin
        strobe_next       = 1'b1;
        kind_next         = KIND_FILL_REQ;
        result_block_next = held_id;
        last_next         = 1'b1;
        state_next        = ST_IDLE;
      end
      ST_SPILL: begin
        strobe_next       = 1'b1;
        kind_next         = KIND_SPILL;
        result_block_next = held_id;
        word_index_next   = INDEX_W'(spill_idx);
        word_value_next   = mem_rdata;
        if (spill_idx == ADDR_LAST) begin
          mem_raddr  = '0;
          state_next = ST_DONE;
        end else begin
          mem_raddr      = spill_idx + ADDR_ONE;
          spill_idx_next = spill_idx + ADDR_ONE;
        end
      end
      ST_DONE: begin
        mem_we            = 1'b1;
        mem_waddr         = '0;
        mem_wdata         = held_id;
        entry_count_next  = COUNT_ONE;
        strobe_next       = 1'b1;
        kind_next         = KIND_ACCEPTED;
        result_block_next = held_id;
        last_next         = 1'b1;
        state_next        = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      entry_count   <= '0;
      chain_first   <= '0;
      refilling     <= 1'b0;
      fill_position <= '0;
      spill_idx     <= '0;
      strobe        <= 1'b0;
    end else begin
      state         <= state_next;
      entry_count   <= entry_count_next;
      chain_first   <= chain_first_next;
      refilling     <= refilling_next;
      fill_position <= fill_position_next;
      spill_idx     <= spill_idx_next;
      strobe        <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    held_id      <= held_id_next;
    kind         <= kind_next;
    result_block <= result_block_next;
    word_index   <= word_index_next;
    word_value   <= word_value_next;
    last         <= last_next;
  end

  a_last_frees: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("final word issued while still busy");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= COUNT_FULL)
    else $error("entry count beyond stack depth");

  a_refill_empty: assert property (@(posedge clk) disable iff (rst)
    refilling |-> entry_count == '0)
    else $error("stack not empty during refill");

  a_spill_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && kind == KIND_SPILL |-> !last)
    else $error("spill word marked last");

  a_spill_streams: assert property (@(posedge clk) disable iff (rst)
    state == ST_SPILL |=> strobe)
    else $error("spill cycle without a word");

endmodule

/* sv/free_block_stack_allocator.sv */
// Free block allocator: a stack of free block numbers in a one-port-read,
// one-port-write memory with a registered read port. start is taken when busy
// is low. Reclaim that fits the stack, refused commands, fill words and ignored
// modes finish without leaving idle; allocate waits in a state for the memory
// read, and passes through a fill request state when it also issues a fill
// request; reclaim on a full stack streams one spill word per cycle from the
// memory read port, then pushes the new block. Results are registered, one word
// per cycle with strobe high for exactly that cycle; the receiver cannot stall,
// so it must take every strobed word. last marks the final word of each command that issues words.
module free_block_stack_allocator #(
  parameter int STACK_DEPTH = fbsa_pkg::DEFAULT_STACK_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic [fbsa_pkg::MODE_W-1:0]  mode,
  input  logic [fbsa_pkg::WORD_W-1:0]  block_id,
  input  logic [fbsa_pkg::WORD_W-1:0]  fill_word,
  output logic                         strobe,
  output logic [fbsa_pkg::KIND_W-1:0]  kind,
  output logic [fbsa_pkg::WORD_W-1:0]  result_block,
  output logic [fbsa_pkg::INDEX_W-1:0] word_index,
  output logic [fbsa_pkg::WORD_W-1:0]  word_value,
  output logic                         last,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [fbsa_pkg::WORD_W-1:0]  cfg_data
);
  import fbsa_pkg::*;

  localparam int ADDR_W  = $clog2(STACK_DEPTH);
  localparam int COUNT_W = $clog2(STACK_DEPTH + 1);

  logic [WORD_W-1:0] max_blocks;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [WORD_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [WORD_W-1:0] mem_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_blocks <= '0;
    end else if (cfg_valid && cfg_ready) begin
      max_blocks <= cfg_data;
    end
  end

  fbsa_stack_mem #(
    .DEPTH  (STACK_DEPTH),
    .ADDR_W (ADDR_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  fbsa_ctrl #(
    .STACK_DEPTH (STACK_DEPTH),
    .ADDR_W      (ADDR_W),
    .COUNT_W     (COUNT_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .block_id     (block_id),
    .fill_word    (fill_word),
    .max_blocks   (max_blocks),
    .mem_we       (mem_we),
    .mem_waddr    (mem_waddr),
    .mem_wdata    (mem_wdata),
    .mem_raddr    (mem_raddr),
    .mem_rdata    (mem_rdata),
    .strobe       (strobe),
    .kind         (kind),
    .result_block (result_block),
    .word_index   (word_index),
    .word_value   (word_value),
    .last         (last)
  );

endmodule

/* sim/tb_free_block_stack_allocator.sv */
module tb_free_block_stack_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  import fbsa_pkg::*;

  localparam int DEPTH = DEFAULT_STACK_DEPTH;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;

  typedef struct {
    logic [KIND_W-1:0]  kind;
    logic [WORD_W-1:0]  blk;
    logic [INDEX_W-1:0] idx;
    logic [WORD_W-1:0]  val;
    logic               last;
  } alloc_word_t;

  class free_list_shadow;
    logic [WORD_W-1:0] limit;
    logic [WORD_W-1:0] entries [DEPTH];
    int unsigned       depth_used;
    logic [WORD_W-1:0] chain_head;
    bit                refilling;
    int unsigned       fill_pos;
    alloc_word_t       owed_words[$];
    int unsigned       fails;

    function new();
      limit = '0;
      foreach (entries[i]) entries[i] = '0;
      depth_used = 0;
      chain_head = '0;
      refilling = 0;
      fill_pos = 0;
      fails = 0;
    endfunction

    function void owe(logic [KIND_W-1:0] k, logic [WORD_W-1:0] b, logic [INDEX_W-1:0] i,
                      logic [WORD_W-1:0] v, logic l);
      alloc_word_t w;
      w.kind = k;
      w.blk = b;
      w.idx = i;
      w.val = v;
      w.last = l;
      owed_words.push_back(w);
    endfunction

    function void take_command(logic [MODE_W-1:0] m, logic [WORD_W-1:0] id,
                               logic [WORD_W-1:0] fw);
      logic [WORD_W-1:0] top;
      int k;
      if (m == MODE_FILL) begin
        if (refilling) begin
          entries[fill_pos] = fw;
          fill_pos++;
          if (fill_pos == DEPTH) begin
            depth_used = DEPTH;
            refilling = 0;
            fill_pos = 0;
          end
        end
        return;
      end
      if (m == MODE_IGNORED) return;
      if (refilling) begin
        owe(KIND_REFUSED, '0, '0, '0, 1'b1);
        return;
      end
      if (m == MODE_ALLOC) begin
        if (depth_used == 0) begin
          owe(KIND_REFUSED, '0, '0, '0, 1'b1);
          return;
        end
        top = entries[depth_used-1];
        if (depth_used == 1 && top != chain_head) begin
          depth_used = 0;
          refilling = 1;
          fill_pos = 0;
          owe(KIND_GRANTED, top, '0, '0, 1'b0);
          owe(KIND_FILL_REQ, top, '0, '0, 1'b1);
        end else begin
          depth_used--;
          owe(KIND_GRANTED, top, '0, '0, 1'b1);
        end
        return;
      end
      if (id >= limit) begin
        owe(KIND_REFUSED, '0, '0, '0, 1'b1);
        return;
      end
      if (depth_used == 0) chain_head = id;
      if (depth_used == DEPTH) begin
        for (k = 0; k < DEPTH; k++) owe(KIND_SPILL, id, INDEX_W'(k), entries[k], 1'b0);
        entries[0] = id;
        depth_used = 1;
      end else begin
        entries[depth_used] = id;
        depth_used++;
      end
      owe(KIND_ACCEPTED, id, '0, '0, 1'b1);
    endfunction

    function void check_word(alloc_word_t got);
      alloc_word_t exp_w;
      if (owed_words.size() == 0) begin
        $error("unexpected word: kind %0d block %0h", got.kind, got.blk);
        fails++;
        return;
      end
      exp_w = owed_words.pop_front();
      if (got.kind !== exp_w.kind) begin
        $error("kind: expected %0d, got %0d", exp_w.kind, got.kind);
        fails++;
      end
      if (got.blk !== exp_w.blk) begin
        $error("result_block: expected %0h, got %0h", exp_w.blk, got.blk);
        fails++;
      end
      if (got.idx !== exp_w.idx) begin
        $error("word_index: expected %0d, got %0d", exp_w.idx, got.idx);
        fails++;
      end
      if (got.val !== exp_w.val) begin
        $error("word_value: expected %0h, got %0h", exp_w.val, got.val);
        fails++;
      end
      if (got.last !== exp_w.last) begin
        $error("last: expected %0b, got %0b", exp_w.last, got.last);
        fails++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst;
  logic                start;
  logic                busy;
  logic [MODE_W-1:0]   mode;
  logic [WORD_W-1:0]   block_id;
  logic [WORD_W-1:0]   fill_word;
  logic                strobe;
  logic [KIND_W-1:0]   kind;
  logic [WORD_W-1:0]   result_block;
  logic [INDEX_W-1:0]  word_index;
  logic [WORD_W-1:0]   word_value;
  logic                last;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [WORD_W-1:0]   cfg_data;

  free_list_shadow shadow = new();
  alloc_word_t     seen;
  int              cycles = 0;
  bit              growing = 1;

  free_block_stack_allocator #(.STACK_DEPTH(DEPTH)) u_top (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .mode         (mode),
    .block_id     (block_id),
    .fill_word    (fill_word),
    .strobe       (strobe),
    .kind         (kind),
    .result_block (result_block),
    .word_index   (word_index),
    .word_value   (word_value),
    .last         (last),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && strobe) begin
      seen.kind = kind;
      seen.blk = result_block;
      seen.idx = word_index;
      seen.val = word_value;
      seen.last = last;
      shadow.check_word(seen);
    end
  end

  task automatic send_word(logic [MODE_W-1:0] m, logic [WORD_W-1:0] id,
                           logic [WORD_W-1:0] fw);
    start <= 1'b1;
    mode <= m;
    block_id <= id;
    fill_word <= fw;
    do @(posedge clk); while (busy);
    shadow.take_command(m, id, fw);
  endtask

  task automatic take_gap();
    int r;
    int n;
    r = $urandom_range(99, 0);
    n = 0;
    if (r >= 60 && r < 94) n = $urandom_range(3, 1);
    else if (r >= 94) n = $urandom_range(40, 8);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain_all();
    start <= 1'b0;
    while (shadow.owed_words.size() != 0) @(posedge clk);
    repeat (DEPTH + 4) @(posedge clk);
  endtask

  task automatic write_limit(logic [WORD_W-1:0] v);
    drain_all();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shadow.limit = v;
  endtask

  function automatic logic [WORD_W-1:0] pick_id(bit good);
    logic [WORD_W-1:0] lim;
    int r;
    lim = shadow.limit;
    r = $urandom_range(99, 0);
    if (good && lim != 0) begin
      if (r < 20) return lim - 1;
      if (r < 30) return '0;
      return $urandom_range(lim - 1, 0);
    end
    if (r < 30) return lim;
    return $urandom_range(32'hFFFF_FFFF, lim);
  endfunction

  task automatic run_phase(int unsigned n, bit steady);
    int unsigned done_items;
    int unsigned before_depth;
    int r;
    logic [MODE_W-1:0] m;
    logic [WORD_W-1:0] id;
    bit ign;
    done_items = 0;
    while (done_items < n) begin
      r = $urandom_range(99, 0);
      id = pick_id(1'b1);
      if (shadow.refilling) begin
        if (r < 88) m = MODE_FILL;
        else if (r < 93) m = MODE_ALLOC;
        else if (r < 97) m = MODE_RECLAIM;
        else m = MODE_IGNORED;
      end else if (growing) begin
        if (r < 72) m = MODE_RECLAIM;
        else if (r < 82) begin
          m = MODE_RECLAIM;
          id = pick_id(1'b0);
        end else if (r < 92) m = MODE_ALLOC;
        else if (r < 96) m = MODE_FILL;
        else m = MODE_IGNORED;
      end else begin
        if (r < 70) m = MODE_ALLOC;
        else if (r < 85) m = MODE_RECLAIM;
        else if (r < 92) begin
          m = MODE_RECLAIM;
          id = pick_id(1'b0);
        end else if (r < 96) m = MODE_FILL;
        else m = MODE_IGNORED;
      end
      ign = (m == MODE_IGNORED) || (m == MODE_FILL && !shadow.refilling);
      before_depth = shadow.depth_used;
      send_word(m, id, $urandom());
      if (!ign) done_items++;
      if (growing && before_depth == DEPTH && shadow.depth_used == 1) growing = 0;
      else if (!growing && !shadow.refilling &&
               (shadow.depth_used == 0 || $urandom_range(99, 0) < 3)) growing = 1;
      if (!steady) take_gap();
    end
  endtask

  initial begin
    rst <= 1'b1;
    start <= 1'b0;
    mode <= MODE_ALLOC;
    block_id <= '0;
    fill_word <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // limit 0 after reset: everything refused or ignored
    send_word(MODE_ALLOC, '0, '0);
    send_word(MODE_RECLAIM, '0, '0);
    send_word(MODE_RECLAIM, 32'hFFFF_FFFF, '0);
    send_word(MODE_FILL, '0, 32'h1234_5678);
    send_word(MODE_IGNORED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

    write_limit(32'hFFFF_FFFF);
    send_word(MODE_RECLAIM, 32'hFFFF_FFFE, '0);
    send_word(MODE_RECLAIM, '0, '0);
    send_word(MODE_RECLAIM, 32'h5555_5555, '0);
    send_word(MODE_RECLAIM, 32'hFFFF_FFFF, '0);
    send_word(MODE_ALLOC, '0, '0);
    send_word(MODE_ALLOC, '0, '0);
    send_word(MODE_ALLOC, '0, '0);
    send_word(MODE_ALLOC, '0, '0);
    send_word(MODE_RECLAIM, 32'hAAAA_AAAA, '0);
    send_word(MODE_RECLAIM, 32'h7, '0);
    send_word(MODE_ALLOC, '0, '0);
    send_word(MODE_ALLOC, '0, '0);

    // random part, one limit per phase
    growing = 1;
    run_phase(90, 1'b0);
    write_limit(32'd1);
    run_phase(30, 1'b1);
    write_limit($urandom_range(1000, 2));
    run_phase(60, 1'b0);
    write_limit(32'h8000_0000);
    run_phase(60, 1'b0);
    write_limit(32'd0);
    run_phase(10, 1'b0);

    drain_all();
    repeat (8) @(posedge clk);
    if (shadow.fails == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
